// File: hdl/assert_macros.svh
// Assertion macros shared by the go-to-goal controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising clk_i edge outside reset.
`define GTG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// Checked on every rising clk_i edge, reset included.
`define GTG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define GTG_ASSERT(lbl, prop)
`define GTG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// File: hdl/gtg_pkg.sv
// Package with constants, register codes and the arctangent table of the controller.
`default_nettype none
package gtg_pkg;
  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned SqrtSteps = 17;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam logic signed [15:0] PiQ12 = 16'sd12868;
  localparam logic signed [31:0] HalfPiQ28 = 32'sd421657428;

  typedef enum logic [CfgAddrW-1:0] {
    REG_GOAL_X    = 3'd0,
    REG_GOAL_Y    = 3'd1,
    REG_TOLERANCE = 3'd2,
    REG_LIN_GAIN  = 3'd3,
    REG_ANG_GAIN  = 3'd4
  } cfg_reg_e;

  localparam logic [15:0] GoalXRst = 16'd12288;
  localparam logic [15:0] GoalYRst = 16'd12288;
  localparam logic [15:0] TolRst = 16'd410;
  localparam logic [11:0] LinGainRst = 12'd384;
  localparam logic [11:0] AngGainRst = 12'd1536;

  // atan(2^-i) in radians times 2^28, rounded to nearest.
  function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0: r = 32'sd210828714;
      5'd1: r = 32'sd124459457;
      5'd2: r = 32'sd65760959;
      5'd3: r = 32'sd33381290;
      5'd4: r = 32'sd16755422;
      5'd5: r = 32'sd8385879;
      5'd6: r = 32'sd4193963;
      5'd7: r = 32'sd2097109;
      5'd8: r = 32'sd1048571;
      5'd9: r = 32'sd524287;
      5'd10: r = 32'sd262144;
      5'd11: r = 32'sd131072;
      5'd12: r = 32'sd65536;
      5'd13: r = 32'sd32768;
      5'd14: r = 32'sd16384;
      5'd15: r = 32'sd8192;
      5'd16: r = 32'sd4096;
      5'd17: r = 32'sd2048;
      5'd18: r = 32'sd1024;
      5'd19: r = 32'sd512;
      5'd20: r = 32'sd256;
      5'd21: r = 32'sd128;
      5'd22: r = 32'sd64;
      5'd23: r = 32'sd32;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

// File: hdl/gtg_ifs.sv
// Handshake interfaces for the pose, command and configuration channels.
`default_nettype none
interface gtg_pose_if;
  logic               valid;
  logic               ready;
  logic        [15:0] pose_x;
  logic        [15:0] pose_y;
  logic signed [14:0] pose_theta;
  modport source (output valid, pose_x, pose_y, pose_theta, input ready);
  modport sink (input valid, pose_x, pose_y, pose_theta, output ready);
endinterface

interface gtg_cmd_if;
  logic               valid;
  logic               ready;
  logic        [22:0] linear_vel;
  logic signed [23:0] angular_vel;
  logic               at_goal;
  modport source (output valid, linear_vel, angular_vel, at_goal, input ready);
  modport sink (input valid, linear_vel, angular_vel, at_goal, output ready);
endinterface

interface gtg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gtg_pkg::CfgAddrW-1:0]    addr;
  logic [gtg_pkg::CfgDataW-1:0]    data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface
`default_nettype wire

// File: hdl/go_to_goal_p_controller_core.sv
// Go-to-goal proportional controller: one velocity command item per pose item.
//
// Channels: pose_i takes a pose item (x, y, heading), cmd_o gives one command
// item per pose (linear and angular velocity, at_goal flag), cfg_i writes the
// goal, tolerance and gain registers; it is always ready and is to be written
// only while no pose item is in flight.
// Throughput: one pose item per cycle while cmd_o is not stalled. A pose passes
// through the offset, squaring and summing stages, the square root pipeline
// (one root bit per stage) running alongside the CORDIC (one rotation per
// stage), and two output steps.
// The whole pipeline moves as one: when cmd_o is stalled with a command held,
// every stage holds and pose_i.ready drops; a waiting command never blocks
// a new pose while the output register is free or being taken.
// Reset clears all valid bits and loads the default goal (3.0, 3.0),
// tolerance 0.1, linear gain 1.5 and angular gain 6.0.
`default_nettype none
`include "assert_macros.svh"
module go_to_goal_p_controller_core #(
  parameter int unsigned CORDIC_STAGES = gtg_pkg::CordicStagesDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gtg_pose_if.sink  pose_i,
  gtg_cmd_if.source cmd_o,
  gtg_cfg_if.sink   cfg_i
);
  localparam int unsigned NS = (CORDIC_STAGES > gtg_pkg::SqrtSteps) ?
                               CORDIC_STAGES : gtg_pkg::SqrtSteps;

  // Configuration registers.
  logic [15:0] goal_x_q, goal_y_q, tol_q;
  logic [11:0] lin_gain_q, ang_gain_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q   <= gtg_pkg::GoalXRst;
      goal_y_q   <= gtg_pkg::GoalYRst;
      tol_q      <= gtg_pkg::TolRst;
      lin_gain_q <= gtg_pkg::LinGainRst;
      ang_gain_q <= gtg_pkg::AngGainRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        gtg_pkg::REG_GOAL_X:    goal_x_q <= cfg_i.data;
        gtg_pkg::REG_GOAL_Y:    goal_y_q <= cfg_i.data;
        gtg_pkg::REG_TOLERANCE: tol_q <= cfg_i.data;
        gtg_pkg::REG_LIN_GAIN:  lin_gain_q <= cfg_i.data[11:0];
        gtg_pkg::REG_ANG_GAIN:  ang_gain_q <= cfg_i.data[11:0];
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic adv;
  assign adv = !out_vld_q || cmd_o.ready;
  assign pose_i.ready = adv;

  // Stage 1: offsets and CORDIC pre-rotation into the right half plane.
  logic signed [16:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [36:0] xs_d, ys_d, x1_d, y1_d;
  logic signed [31:0] z1_d;
  logic signed [36:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
  logic signed [31:0] z1_q, z2_q, z3_q;
  logic signed [14:0] th1_q, th2_q, th3_q;
  logic zero1_q, zero2_q, zero3_q;
  logic v1_q, v2_q, v3_q;

  assign dx_d = $signed({1'b0, goal_x_q}) - $signed({1'b0, pose_i.pose_x});
  assign dy_d = $signed({1'b0, goal_y_q}) - $signed({1'b0, pose_i.pose_y});
  assign xs_d = {{4{dx_d[16]}}, dx_d, 16'h0000};
  assign ys_d = {{4{dy_d[16]}}, dy_d, 16'h0000};

  always_comb begin
    x1_d = xs_d;
    y1_d = ys_d;
    z1_d = '0;
    if (xs_d[36]) begin
      if (!ys_d[36]) begin
        x1_d = ys_d;
        y1_d = -xs_d;
        z1_d = gtg_pkg::HalfPiQ28;
      end else begin
        x1_d = -ys_d;
        y1_d = xs_d;
        z1_d = -gtg_pkg::HalfPiQ28;
      end
    end
  end

  // Stage 2: squares. Stage 3: their sum.
  logic signed [33:0] sqx, sqy;
  logic [31:0] sqx_q, sqy_q;
  logic [32:0] sum_q;
  assign sqx = dx_q * dx_q;
  assign sqy = dy_q * dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= pose_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      x1_q <= x1_d;
      y1_q <= y1_d;
      z1_q <= z1_d;
      th1_q <= pose_i.pose_theta;
      zero1_q <= (dx_d == '0) && (dy_d == '0);
      sqx_q <= sqx[31:0];
      sqy_q <= sqy[31:0];
      x2_q <= x1_q;
      y2_q <= y1_q;
      z2_q <= z1_q;
      th2_q <= th1_q;
      zero2_q <= zero1_q;
      sum_q <= {1'b0, sqx_q} + {1'b0, sqy_q};
      x3_q <= x2_q;
      y3_q <= y2_q;
      z3_q <= z2_q;
      th3_q <= th2_q;
      zero3_q <= zero2_q;
    end
  end

  // Iterative stage k: root bit if k < SqrtSteps, rotation if k < CORDIC_STAGES.
  // Entry 0 is the stage 3 output, entry k+1 the register of stage k.
  logic [33:0]        rad_s [NS+1];
  logic [19:0]        rem_s [NS+1];
  logic [16:0]        root_s [NS+1];
  logic signed [36:0] x_s [NS+1];
  logic signed [36:0] y_s [NS+1];
  logic signed [31:0] z_s [NS+1];
  logic signed [14:0] th_s [NS+1];
  logic               zero_s [NS+1];
  logic [NS:0]        vld_s;

  assign rad_s[0]  = {1'b0, sum_q};
  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign x_s[0]    = x3_q;
  assign y_s[0]    = y3_q;
  assign z_s[0]    = z3_q;
  assign th_s[0]   = th3_q;
  assign zero_s[0] = zero3_q;
  assign vld_s[0]  = v3_q;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [19:0]        rem_n, tmp, trial;
    logic [16:0]        root_n;
    logic signed [36:0] x_n, y_n, xsh, ysh;
    logic signed [31:0] z_n, at;

    always_comb begin
      tmp   = {rem_s[k][17:0], rad_s[k][33:32]};
      trial = {1'b0, root_s[k], 2'b01};
      rem_n  = rem_s[k];
      root_n = root_s[k];
      if (k < gtg_pkg::SqrtSteps) begin
        if (tmp >= trial) begin
          rem_n  = tmp - trial;
          root_n = {root_s[k][15:0], 1'b1};
        end else begin
          rem_n  = tmp;
          root_n = {root_s[k][15:0], 1'b0};
        end
      end
    end

    assign xsh = x_s[k] >>> k;
    assign ysh = y_s[k] >>> k;
    assign at  = gtg_pkg::atan_q28(5'(k));

    always_comb begin
      x_n = x_s[k];
      y_n = y_s[k];
      z_n = z_s[k];
      if (k < CORDIC_STAGES) begin
        if (!y_s[k][36]) begin
          x_n = x_s[k] + ysh;
          y_n = y_s[k] - xsh;
          z_n = z_s[k] + at;
        end else begin
          x_n = x_s[k] - ysh;
          y_n = y_s[k] + xsh;
          z_n = z_s[k] - at;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_s[k+1] <= 1'b0;
      end else if (adv) begin
        vld_s[k+1] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        rad_s[k+1]  <= {rad_s[k][31:0], 2'b00};
        rem_s[k+1]  <= rem_n;
        root_s[k+1] <= root_n;
        x_s[k+1]    <= x_n;
        y_s[k+1]    <= y_n;
        z_s[k+1]    <= z_n;
        th_s[k+1]   <= th_s[k];
        zero_s[k+1] <= zero_s[k];
      end
    end
  end

  // Final stage 1: bearing rounding and clamp, heading error, goal check.
  logic signed [31:0] zr;
  logic signed [15:0] bear_raw, bear;
  logic [16:0]        dist_q;
  logic signed [16:0] err_q;
  logic               goal_q, f1_vld_q;

  assign zr = z_s[NS] + 32'sd32768;
  assign bear_raw = zr[31:16];

  always_comb begin
    if (zero_s[NS]) begin
      bear = '0;
    end else if (bear_raw > gtg_pkg::PiQ12) begin
      bear = gtg_pkg::PiQ12;
    end else if (bear_raw < -gtg_pkg::PiQ12) begin
      bear = -gtg_pkg::PiQ12;
    end else begin
      bear = bear_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      f1_vld_q  <= vld_s[NS];
      out_vld_q <= f1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= root_s[NS];
      err_q  <= {bear[15], bear} - {{2{th_s[NS][14]}}, th_s[NS]};
      goal_q <= {1'b0, root_s[NS]} < {1'b0, tol_q};
    end
  end

  // Final stage 2: gains and rounding into the output register, zero at goal.
  logic [28:0]        lin_prod;
  logic [28:0]        lin_rnd;
  logic signed [29:0] ang_prod, ang_rnd;
  logic [22:0]        lin_q;
  logic signed [23:0] ang_q;
  logic               at_goal_q;

  assign lin_prod = {5'b0, lin_gain_q} * {12'b0, dist_q};
  assign lin_rnd  = lin_prod + 29'd128;
  assign ang_prod = $signed({1'b0, ang_gain_q}) * err_q;
  assign ang_rnd  = ang_prod + 30'sd128;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      at_goal_q <= goal_q;
      if (goal_q) begin
        lin_q <= '0;
        ang_q <= '0;
      end else begin
        lin_q <= {2'b00, lin_rnd[28:8]};
        ang_q <= {{2{ang_rnd[29]}}, ang_rnd[29:8]};
      end
    end
  end

  assign cmd_o.valid       = out_vld_q;
  assign cmd_o.linear_vel  = lin_q;
  assign cmd_o.angular_vel = ang_q;
  assign cmd_o.at_goal     = at_goal_q;

  `GTG_ASSERT(a_goal_zero, out_vld_q && at_goal_q |-> lin_q == '0 && ang_q == '0)
  `GTG_ASSERT(a_hold_on_stall, !adv |=> $stable(vld_s) && $stable(f1_vld_q))
  `GTG_ASSERT(a_goal_dist, f1_vld_q && adv |=> at_goal_q == ($past(dist_q) < $past({1'b0, tol_q})))
  `GTG_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> vld_s[NS:1] == '0 && !out_vld_q)
endmodule
`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the go-to-goal proportional controller core.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [22:0]        lin;
    logic signed [23:0] ang;
    logic               at_goal;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gtg_pose_if pose_if ();
  gtg_cmd_if  cmd_if ();
  gtg_cfg_if  cfg_if ();

  go_to_goal_p_controller_core uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pose_i(pose_if.sink),
    .cmd_o (cmd_if.source),
    .cfg_i (cfg_if.sink)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the controller registers.
  logic [15:0] goal_x_q, goal_y_q, tol_q;
  logic [11:0] lin_gain_q, ang_gain_q;

  cmd_t   cmd_queue[$];
  int     n_errors = 0;
  int     n_cmds = 0;
  int     n_goal = 0;
  int     send_idle = 0;
  int     recv_idle = 0;

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d, expected %0d (command %0d)", what, got, want, n_cmds);
    n_errors++;
  endtask

  function automatic longint shr_floor(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint int_sqrt(input longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic longint heading_to_goal(input longint dx, input longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    // Fold the left half plane into the CORDIC's convergence range.
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = gtg_pkg::HalfPiQ28;
      end else begin
        t = x; x = -y; y = t; z = -gtg_pkg::HalfPiQ28;
      end
    end
    for (int i = 0; i < gtg_pkg::CordicStagesDef && i < 24; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(gtg_pkg::atan_q28(5'(i)));
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(gtg_pkg::atan_q28(5'(i)));
      end
    end
    z = shr_floor(z + 32768, 16);
    if (z > gtg_pkg::PiQ12) z = gtg_pkg::PiQ12;
    if (z < -gtg_pkg::PiQ12) z = -gtg_pkg::PiQ12;
    return z;
  endfunction

  function automatic cmd_t steer_command(input logic [15:0] px, input logic [15:0] py,
                                         input logic signed [14:0] th);
    cmd_t   c;
    longint dx, dy, dist_v, err;
    dx = longint'(goal_x_q) - longint'(px);
    dy = longint'(goal_y_q) - longint'(py);
    dist_v = int_sqrt(dx * dx + dy * dy);
    if (dist_v >= longint'(tol_q)) begin
      err = heading_to_goal(dx, dy) - longint'(th);
      c.lin = 23'((longint'(lin_gain_q) * dist_v + 128) >>> 8);
      c.ang = 24'(shr_floor(longint'(ang_gain_q) * err + 128, 8));
      c.at_goal = 1'b0;
    end else begin
      c = '0;
      c.at_goal = 1'b1;
    end
    return c;
  endfunction

  // Valid stays high after an accepted item so that items can follow back to back;
  // idling and draining take it low.
  task automatic send_pose(input logic [15:0] px, input logic [15:0] py,
                           input logic signed [14:0] th);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      pose_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    pose_if.valid <= 1'b1;
    pose_if.pose_x <= px;
    pose_if.pose_y <= py;
    pose_if.pose_theta <= th;
    @(posedge clk_i);
    while (!pose_if.ready) @(posedge clk_i);
    cmd_queue.push_back(steer_command(px, py, th));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    pose_if.valid <= 1'b0;
    while (cmd_queue.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [gtg_pkg::CfgAddrW-1:0] idx, input logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.addr <= idx;
    cfg_if.data <= val;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      gtg_pkg::REG_GOAL_X:    goal_x_q = val;
      gtg_pkg::REG_GOAL_Y:    goal_y_q = val;
      gtg_pkg::REG_TOLERANCE: tol_q = val;
      gtg_pkg::REG_LIN_GAIN:  lin_gain_q = val[11:0];
      gtg_pkg::REG_ANG_GAIN:  ang_gain_q = val[11:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(input logic [15:0] gx, input logic [15:0] gy, input logic [15:0] tol,
                         input logic [15:0] lg, input logic [15:0] ag);
    wait_drained();
    write_reg(gtg_pkg::REG_GOAL_X, gx);
    write_reg(gtg_pkg::REG_GOAL_Y, gy);
    write_reg(gtg_pkg::REG_TOLERANCE, tol);
    write_reg(gtg_pkg::REG_LIN_GAIN, lg);
    write_reg(gtg_pkg::REG_ANG_GAIN, ag);
  endtask

  function automatic logic signed [14:0] rand_heading();
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(25736)) - 12868);
  endfunction

  // Checker: compares every accepted command with the oldest expectation.
  always @(posedge clk_i) begin
    cmd_t exp_c;
    if (rst_ni && cmd_if.valid && cmd_if.ready) begin
      if (cmd_queue.size() == 0) begin
        $display("MISMATCH: unexpected command item");
        n_errors++;
      end else begin
        exp_c = cmd_queue.pop_front();
        if (cmd_if.linear_vel !== exp_c.lin) report("linear_vel", cmd_if.linear_vel, exp_c.lin);
        if (cmd_if.angular_vel !== exp_c.ang)
          report("angular_vel", cmd_if.angular_vel, exp_c.ang);
        if (cmd_if.at_goal !== exp_c.at_goal) report("at_goal", cmd_if.at_goal, exp_c.at_goal);
        if (exp_c.at_goal) n_goal++;
      end
      n_cmds++;
    end
  end

  always @(negedge clk_i) begin
    if (recv_idle > 0) cmd_if.ready <= ($urandom_range(99) >= recv_idle);
    else cmd_if.ready <= 1'b1;
  end

  task automatic test_defaults();
    send_pose(16'd12288, 16'd12288, 15'sd0);
    send_pose(16'd0, 16'd0, 15'sd0);
    send_pose(16'hFFFF, 16'hFFFF, 15'sd12868);
    send_pose(16'hFFFF, 16'd0, -15'sd12868);
    send_pose(16'd0, 16'hFFFF, 15'sd16383);
    send_pose(16'd12288, 16'd0, -15'sd16384);
    send_pose(16'd20000, 16'd12288, 15'sd0);
    send_pose(16'd12000, 16'd12288, 15'sd5);
    send_pose(16'd12288, 16'd12600, 15'sd0);
  endtask

  task automatic test_extremes();
    // Zero tolerance with zero offset makes the bearing zero.
    set_all(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
    send_pose(16'd0, 16'hFFFF, 15'sd100);
    send_pose(16'hFFFF, 16'd0, -15'sd12868);
    send_pose(16'hFFFF, 16'hFFFF, 15'sd12868);
    send_pose(16'd0, 16'd0, -15'sd16384);
    set_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0);
    send_pose(16'd0, 16'hFFFF, 15'sd0);
    send_pose(16'd65000, 16'd10, 15'sd0);
    set_all(16'd30000, 16'd30000, 16'd1, 16'hF123, 16'hF800);
    send_pose(16'd30000, 16'd30000, 15'sd0);
    send_pose(16'd30001, 16'd30000, 15'sd7);
    // Unknown register indexes must be ignored.
    wait_drained();
    write_reg(3'd5, 16'h1234);
    write_reg(3'd6, 16'hBEEF);
    write_reg(3'd7, 16'hFFFF);
    send_pose(16'd100, 16'd50000, -15'sd1);
  endtask

  task automatic random_phase(input int n, input int s_idle, input int r_idle);
    logic [15:0] px, py;
    set_all(16'($urandom), 16'($urandom), 16'($urandom_range(8000)),
            16'($urandom), 16'($urandom));
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        px = goal_x_q + 16'($urandom_range(800)) - 16'd400;
        py = goal_y_q + 16'($urandom_range(800)) - 16'd400;
      end else begin
        px = 16'($urandom);
        py = 16'($urandom);
      end
      send_pose(px, py, rand_heading());
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    pose_if.valid = 1'b0;
    pose_if.pose_x = '0;
    pose_if.pose_y = '0;
    pose_if.pose_theta = '0;
    cmd_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.addr = '0;
    cfg_if.data = '0;
    goal_x_q = gtg_pkg::GoalXRst;
    goal_y_q = gtg_pkg::GoalYRst;
    tol_q = gtg_pkg::TolRst;
    lin_gain_q = gtg_pkg::LinGainRst;
    ang_gain_q = gtg_pkg::AngGainRst;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_defaults();
    test_extremes();
    for (int p = 0; p < 2; p++) random_phase(115, 31, 80);
    for (int p = 0; p < 2; p++) random_phase(115, 80, 31);
    for (int p = 0; p < 2; p++) random_phase(115, 0, 0);
    send_idle = 0;
    recv_idle = 0;
    wait_drained();
    $display("Sent %0d poses over 10 register settings; %0d commands checked, %0d at goal.",
             n_cmds, n_cmds, n_goal);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for command items.");
    $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
